>>> rtl/core/assert_macros.svh
// Assertion macros for the RTL datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/core/icts_pkg.sv
`timescale 1ns / 1ps
package icts_pkg;

    // Field widths
    localparam int IDX_W      = 12;
    localparam int CDF_W      = 32;
    localparam int U_W        = 31;
    localparam int STEP_W     = 20;
    localparam int ENERGY_W   = 32;
    localparam int STATUS_W   = 2;
    localparam int PROD_W     = U_W + STEP_W;
    localparam int CNT_W      = $clog2(STEP_W);

    // Register port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_ENERGY_STEP = '0;
    localparam logic [STEP_W-1:0]    ENERGY_STEP_RST = STEP_W'(320);

    localparam int TABLE_ENTRIES_DEF = 4096;

    // Transaction kinds
    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    // Clamp codes
    localparam logic [STATUS_W-1:0] CLAMP_NONE = 2'd0;
    localparam logic [STATUS_W-1:0] CLAMP_LOW  = 2'd1;
    localparam logic [STATUS_W-1:0] CLAMP_HIGH = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH,
        S_CMP,
        S_RD0,
        S_RD1,
        S_PREP,
        S_MULF,
        S_MULB,
        S_DIV,
        S_SUM,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        RD_MID,
        RD_LO_M1,
        RD_LO
    } t_rd_sel;

    typedef struct packed {
        logic    start;
        logic    wr;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    cmp;
        logic    cap_c0;
        logic    prep;
        logic    mul_frac;
        logic    mul_base;
        logic    div_step;
        logic    sum;
        logic    res_low;
        logic    out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic search_done;
        logic lo_zero;
        logic lo_full;
        logic div_last;
        logic out_free;
    } t_dp_status;

endpackage

>>> rtl/core/inverse_cdf_table_sampler.sv
`timescale 1ns / 1ps
// Channel   Handshake                  Payload
// input     i_in_valid / o_in_stall    i_func, i_entry_index, i_cdf_value, i_uniform_draw
// output    o_out_valid / i_out_stall  o_energy, o_clamp_status
// register  psel/penable/pwrite/pready paddr, pwdata, prdata (energy_step at 0x0)
//
// A load writes its entry as it is accepted. A sample runs a lower-bound search, each step
// a table read and a compare, up to log2(TABLE_ENTRIES)+1 steps. A low clamp then goes to
// the output; a high clamp takes only the base multiply; else two table reads, a prepare
// step, two passes through the one multiplier and a serial divide come before the sum.
// Reset clears control only; table contents are undefined until loaded.
// A stalled result sits in the output register while the next transaction is taken.
module inverse_cdf_table_sampler
    import icts_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_func,
    input  logic [IDX_W-1:0]      i_entry_index,
    input  logic [CDF_W-1:0]      i_cdf_value,
    input  logic [U_W-1:0]        i_uniform_draw,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [ENERGY_W-1:0]   o_energy,
    output logic [STATUS_W-1:0]   o_clamp_status,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [STEP_W-1:0] r_energy_step;
    logic              step_sel;
    t_dp_cmd           cmd;
    t_dp_status        status;

    // Register port
    assign pready   = 1'b1;
    assign step_sel = (paddr[APB_ADDR_W-1:2] == REG_ENERGY_STEP);
    assign prdata   = step_sel ? APB_DATA_W'(r_energy_step) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_energy_step <= ENERGY_STEP_RST;
        end else if (psel && penable && pwrite && pready && step_sel) begin
            r_energy_step <= pwdata[STEP_W-1:0];
        end
    end

    icts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_func     (i_func),
        .i_status   (status),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    icts_dpath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_entry_index  (i_entry_index),
        .i_cdf_value    (i_cdf_value),
        .i_uniform_draw (i_uniform_draw),
        .i_energy_step  (r_energy_step),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_energy       (o_energy),
        .o_clamp_status (o_clamp_status)
    );

endmodule

>>> rtl/core/icts_ctrl.sv
`timescale 1ns / 1ps
module icts_ctrl
    import icts_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_func,
    input  t_dp_status i_status,
    output logic       o_in_stall,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   in_acc;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && (i_func == FUNC_SAMPLE)) begin
                    n_state = S_SRCH;
                end
            end
            S_SRCH: begin
                priority if (!i_status.search_done) begin
                    n_state = S_CMP;
                end else if (i_status.lo_zero) begin
                    n_state = S_OUT;
                end else if (i_status.lo_full) begin
                    n_state = S_MULB;
                end else begin
                    n_state = S_RD0;
                end
            end
            S_CMP:  n_state = S_SRCH;
            S_RD0:  n_state = S_RD1;
            S_RD1:  n_state = S_PREP;
            S_PREP: n_state = S_MULF;
            S_MULF: n_state = S_MULB;
            S_MULB: begin
                n_state = i_status.lo_full ? S_SUM : S_DIV;
            end
            S_DIV: begin
                if (i_status.div_last) begin
                    n_state = S_SUM;
                end
            end
            S_SUM:  n_state = S_OUT;
            S_OUT: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath commands
    always_comb begin
        o_cmd        = '0;
        o_cmd.rd_sel = RD_MID;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.start = in_acc && (i_func == FUNC_SAMPLE);
                o_cmd.wr    = in_acc && (i_func == FUNC_LOAD);
            end
            S_SRCH: begin
                o_cmd.rd_en   = !i_status.search_done;
                o_cmd.res_low = i_status.search_done && i_status.lo_zero;
            end
            S_CMP: o_cmd.cmp = 1'b1;
            S_RD0: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_LO_M1;
            end
            S_RD1: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_LO;
                o_cmd.cap_c0 = 1'b1;
            end
            S_PREP: o_cmd.prep     = 1'b1;
            S_MULF: o_cmd.mul_frac = 1'b1;
            S_MULB: o_cmd.mul_base = 1'b1;
            S_DIV:  o_cmd.div_step = 1'b1;
            S_SUM:  o_cmd.sum      = 1'b1;
            S_OUT:  o_cmd.out_load = i_status.out_free;
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

>>> rtl/core/icts_dpath.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module icts_dpath
    import icts_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    output t_dp_status          o_status,
    input  logic [IDX_W-1:0]    i_entry_index,
    input  logic [CDF_W-1:0]    i_cdf_value,
    input  logic [U_W-1:0]      i_uniform_draw,
    input  logic [STEP_W-1:0]   i_energy_step,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output logic [ENERGY_W-1:0] o_energy,
    output logic [STATUS_W-1:0] o_clamp_status
);

    localparam int IW      = $clog2(TABLE_ENTRIES);
    localparam int CW      = IW + 1;
    localparam int IdxExtW = (IDX_W > CW) ? IDX_W : CW;
    localparam logic [CW-1:0] NumEntries = CW'(TABLE_ENTRIES);
    localparam logic [IW-1:0] TopIdx     = IW'(TABLE_ENTRIES - 1);

    // CDF table
    logic [CDF_W-1:0] r_mem [TABLE_ENTRIES];
    logic [CDF_W-1:0] r_rdata;

    logic [U_W-1:0]      r_u;
    logic [CW-1:0]       r_lo;
    logic [CW-1:0]       r_hi;
    logic [IW-1:0]       r_mid;
    logic [CDF_W-1:0]    r_c0;
    logic [CDF_W-1:0]    r_span;
    logic [U_W-1:0]      r_diff;
    logic [PROD_W-1:0]   r_prod;
    logic [CDF_W-1:0]    r_rem;
    logic [STEP_W-1:0]   r_num;
    logic [CNT_W-1:0]    r_cnt;
    logic [ENERGY_W-1:0] r_res_energy;
    logic [STATUS_W-1:0] r_res_status;
    logic                r_out_valid;
    logic [ENERGY_W-1:0] r_out_energy;
    logic [STATUS_W-1:0] r_out_status;

    logic [IdxExtW-1:0]  idx_ext;
    logic                wr_in_range;
    logic [CW:0]         mid_sum;
    logic [IW-1:0]       mid;
    logic [CW-1:0]       lo_m1;
    logic [IW-1:0]       rd_addr;
    logic                lo_full;
    logic [IW-1:0]       base_idx;
    logic [U_W-1:0]      mul_a;
    logic [PROD_W-1:0]   product;
    logic [CDF_W:0]      rem_sh;
    logic                q_bit;
    logic [CDF_W:0]      rem_nx;
    logic [STEP_W-1:0]   frac;
    logic [PROD_W:0]     total;
    logic [ENERGY_W-1:0] energy_sat;
    logic                out_free;

    // Load address check
    assign idx_ext     = IdxExtW'(i_entry_index);
    assign wr_in_range = idx_ext < IdxExtW'(TABLE_ENTRIES);

    // Search midpoint and read address
    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid     = mid_sum[IW:1];
    assign lo_m1   = r_lo - 1'b1;
    assign lo_full = (r_lo == NumEntries);

    always_comb begin
        unique case (i_cmd.rd_sel)
            RD_MID:   rd_addr = mid;
            RD_LO_M1: rd_addr = lo_m1[IW-1:0];
            RD_LO:    rd_addr = r_lo[IW-1:0];
            default:  rd_addr = mid;
        endcase
    end

    // Table write and registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr && wr_in_range) begin
            r_mem[idx_ext[IW-1:0]] <= i_cdf_value;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // Lower-bound search bounds
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lo <= '0;
            r_hi <= NumEntries;
        end else if (i_cmd.start) begin
            r_lo <= '0;
            r_hi <= NumEntries;
        end else if (i_cmd.cmp) begin
            if (r_rdata < CDF_W'(r_u)) begin
                r_lo <= {1'b0, r_mid} + 1'b1;
            end else begin
                r_hi <= {1'b0, r_mid};
            end
        end
    end

    // Shared multiplier: fraction numerator, then grid base
    assign base_idx = lo_full ? TopIdx : lo_m1[IW-1:0];
    assign mul_a    = i_cmd.mul_base ? U_W'(base_idx) : r_diff;
    assign product  = PROD_W'(mul_a) * PROD_W'(i_energy_step);

    // Restoring divide step, one quotient bit a cycle
    assign rem_sh = {r_rem, r_num[STEP_W-1]};
    assign q_bit  = rem_sh >= {1'b0, r_span};
    assign rem_nx = q_bit ? (rem_sh - {1'b0, r_span}) : rem_sh;

    // Final sum with saturation
    assign frac       = lo_full ? '0 : r_num;
    assign total      = {1'b0, r_prod} + (PROD_W + 1)'(frac);
    assign energy_sat = (|total[PROD_W:ENERGY_W]) ? '1 : total[ENERGY_W-1:0];

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_u <= i_uniform_draw;
        end
        if (i_cmd.rd_en && (i_cmd.rd_sel == RD_MID)) begin
            r_mid <= mid;
        end
        if (i_cmd.cap_c0) begin
            r_c0 <= r_rdata;
        end
        if (i_cmd.prep) begin
            // zero-width interval divides by one LSB
            r_span <= (r_rdata > r_c0) ? (r_rdata - r_c0) : CDF_W'(1);
            r_diff <= (CDF_W'(r_u) > r_c0) ? (r_u - r_c0[U_W-1:0]) : '0;
        end
        if (i_cmd.mul_frac) begin
            r_prod <= product;
        end
        if (i_cmd.mul_base) begin
            r_prod <= product;
            r_rem  <= CDF_W'(r_prod[PROD_W-1:STEP_W]);
            r_num  <= r_prod[STEP_W-1:0];
            r_cnt  <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= rem_nx[CDF_W-1:0];
            r_num <= {r_num[STEP_W-2:0], q_bit};
            r_cnt <= r_cnt + 1'b1;
        end
        if (i_cmd.sum) begin
            r_res_energy <= energy_sat;
            r_res_status <= lo_full ? CLAMP_HIGH : CLAMP_NONE;
        end
        if (i_cmd.res_low) begin
            r_res_energy <= '0;
            r_res_status <= CLAMP_LOW;
        end
    end

    // Output register
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_energy <= r_res_energy;
            r_out_status <= r_res_status;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_energy       = r_out_energy;
    assign o_clamp_status = r_out_status;

    // Status to controller
    assign o_status.search_done = !(r_lo < r_hi);
    assign o_status.lo_zero     = (r_lo == '0);
    assign o_status.lo_full     = lo_full;
    assign o_status.div_last    = (r_cnt == CNT_W'(STEP_W - 1));
    assign o_status.out_free    = out_free;

    // Checks
    `ASSERT_IMPLIES(a_bounds_order, i_clk, i_rst_n, 1'b1, r_lo <= r_hi)
    `ASSERT_NEXT(a_search_shrinks, i_clk, i_rst_n, i_cmd.cmp, (r_hi - r_lo) < ($past(r_hi) - $past(r_lo)))
    `ASSERT_IMPLIES(a_rem_below_span, i_clk, i_rst_n, i_cmd.div_step, r_rem < r_span)
    `ASSERT_IMPLIES(a_frac_le_step, i_clk, i_rst_n, i_cmd.sum && !lo_full, r_num <= i_energy_step)

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import icts_pkg::*;

    localparam int          TABLE_ENTRIES = TABLE_ENTRIES_DEF;
    localparam int          SETTLE_CYCLES = 64;
    localparam int          HOLD_CYCLES   = 400;
    localparam int          CYCLE_LIMIT   = 5000000;
    localparam int          IDLE_PERCENT  = 25;
    localparam logic [31:0] CDF_TOP       = 32'h7F00_0000;

    typedef struct {
        logic [ENERGY_W-1:0] energy;
        logic [STATUS_W-1:0] status;
    } t_energy_result;

    // Shadow of the sampler: CDF store, grid step and the energies still owed
    class energy_scoreboard;
        logic [CDF_W-1:0]  cdf_mem [TABLE_ENTRIES];
        logic [STEP_W-1:0] energy_step = ENERGY_STEP_RST;
        t_energy_result    energies_due [$];
        int fails    = 0;
        int checked  = 0;
        int n_loads  = 0;
        int n_draws  = 0;
        int n_low    = 0;
        int n_high   = 0;
        int n_interp = 0;

        // Lower-bound search, then linear interpolation between grid points
        function t_energy_result lookup_energy(logic [U_W-1:0] u);
            t_energy_result r;
            int unsigned    lo, hi, mid;
            logic [63:0]    c0, c1, span, frac, e;
            lo = 0;
            hi = TABLE_ENTRIES;
            while (lo < hi) begin
                mid = (lo + hi) >> 1;
                if (cdf_mem[mid] < {1'b0, u}) lo = mid + 1;
                else hi = mid;
            end
            if (lo == 0) begin
                r.energy = '0;
                r.status = CLAMP_LOW;
                n_low++;
            end else if (lo >= TABLE_ENTRIES) begin
                e = 64'(TABLE_ENTRIES - 1) * 64'(energy_step);
                r.energy = (e > 64'hFFFF_FFFF) ? '1 : ENERGY_W'(e);
                r.status = CLAMP_HIGH;
                n_high++;
            end else begin
                c0   = 64'(cdf_mem[lo - 1]);
                c1   = 64'(cdf_mem[lo]);
                span = (c1 > c0) ? (c1 - c0) : 64'd0;
                if (span < 64'd1) span = 64'd1;
                frac = (64'(u) > c0) ? (64'(u) - c0) : 64'd0;
                frac = (frac * 64'(energy_step)) / span;
                e    = 64'(lo - 1) * 64'(energy_step) + frac;
                r.energy = (e > 64'hFFFF_FFFF) ? '1 : ENERGY_W'(e);
                r.status = CLAMP_NONE;
                n_interp++;
            end
            return r;
        endfunction

        // Accepted input transaction: table write or a new energy owed
        function void note_transaction(logic func, logic [IDX_W-1:0] idx,
                                       logic [CDF_W-1:0] cdf, logic [U_W-1:0] u);
            if (func == FUNC_LOAD) begin
                if (int'(idx) < TABLE_ENTRIES) cdf_mem[idx] = cdf;
                n_loads++;
            end else begin
                energies_due.push_back(lookup_energy(u));
                n_draws++;
            end
        endfunction

        // Accepted output transaction against the oldest energy owed
        function void check_energy(logic [ENERGY_W-1:0] energy,
                                   logic [STATUS_W-1:0] status);
            t_energy_result want;
            if (energies_due.size() == 0) begin
                $error("unexpected result: energy %0d clamp_status %0d", energy, status);
                fails++;
                return;
            end
            want = energies_due.pop_front();
            if (energy !== want.energy) begin
                $error("energy: expected %0d, actual %0d", want.energy, energy);
                fails++;
            end
            if (status !== want.status) begin
                $error("clamp_status: expected %0d, actual %0d", want.status, status);
                fails++;
            end
            checked++;
        endfunction

        function int pending();
            return energies_due.size();
        endfunction
    endclass

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_in_valid     = 1'b0;
    logic                  o_in_stall;
    logic                  i_func         = FUNC_LOAD;
    logic [IDX_W-1:0]      i_entry_index  = '0;
    logic [CDF_W-1:0]      i_cdf_value    = '0;
    logic [U_W-1:0]        i_uniform_draw = '0;
    logic                  o_out_valid;
    logic                  i_out_stall    = 1'b0;
    logic [ENERGY_W-1:0]   o_energy;
    logic [STATUS_W-1:0]   o_clamp_status;
    logic                  psel           = 1'b0;
    logic                  penable        = 1'b0;
    logic                  pwrite         = 1'b0;
    logic [APB_ADDR_W-1:0] paddr          = '0;
    logic [APB_DATA_W-1:0] pwdata         = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    logic quiet       = 1'b0;
    logic hold_go     = 1'b0;
    logic hold_active = 1'b0;

    energy_scoreboard sb = new();

    inverse_cdf_table_sampler #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_func         (i_func),
        .i_entry_index  (i_entry_index),
        .i_cdf_value    (i_cdf_value),
        .i_uniform_draw (i_uniform_draw),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_energy       (o_energy),
        .o_clamp_status (o_clamp_status),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #5 i_clk = ~i_clk;

    // Result side: check on acceptance, then pick the next stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall)
            sb.check_energy(o_energy, o_clamp_status);
        if (hold_active) i_out_stall <= 1'b1;
        else i_out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PERCENT);
    end

    // Long hold-off on the result side so the block backs up into its input
    initial begin : out_hold
        while (!hold_go) @(posedge i_clk);
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_active <= 1'b0;
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("inverse_cdf_table_sampler verification failed");
        $finish;
    end

    // One input transaction, with random idle cycles ahead of it
    task automatic send_item(input logic func, input logic [IDX_W-1:0] idx,
                             input logic [CDF_W-1:0] cdf, input logic [U_W-1:0] u);
        while (!quiet && $urandom_range(0, 99) < IDLE_PERCENT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_func         <= func;
        i_entry_index  <= idx;
        i_cdf_value    <= cdf;
        i_uniform_draw <= u;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_transaction(func, idx, cdf, u);
    endtask

    task automatic do_load(input logic [IDX_W-1:0] idx, input logic [CDF_W-1:0] val);
        send_item(FUNC_LOAD, idx, val, U_W'($urandom));
    endtask

    task automatic do_draw(input logic [U_W-1:0] u);
        send_item(FUNC_SAMPLE, IDX_W'($urandom), $urandom, u);
    endtask

    // Drop valid and wait for every owed energy
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Register write while idle, followed by a read-back
    task automatic write_step(input logic [STEP_W-1:0] val);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_ENERGY_STEP, 2'b00};
        pwdata  <= APB_DATA_W'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.energy_step = val;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata[STEP_W-1:0] !== val) begin
            $error("energy_step: expected %0d, actual %0d", val, prdata[STEP_W-1:0]);
            sb.fails++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Full table load: rising CDF with flats, optionally scrambled entries
    task automatic fill_cdf(input bit scrambled);
        logic [CDF_W-1:0] acc, val;
        acc = $urandom_range(60000, 1000);
        for (int k = 0; k < TABLE_ENTRIES; k++) begin
            val = acc;
            if (scrambled && $urandom_range(0, 99) < 35) val = $urandom;
            do_load(IDX_W'(k), val);
            if ($urandom_range(0, 99) >= 10) acc = acc + $urandom_range(900000, 0);
            if (acc > CDF_TOP) acc = CDF_TOP;
        end
    endtask

    // Draws: mostly inside the table span, some on entries, some anywhere
    function automatic logic [U_W-1:0] pick_draw();
        logic [CDF_W-1:0] a, b, t;
        int unsigned      r;
        r = $urandom_range(0, 99);
        a = sb.cdf_mem[0];
        b = sb.cdf_mem[TABLE_ENTRIES-1];
        if (r < 12) return U_W'($urandom);
        if (r < 24)
            return U_W'(sb.cdf_mem[$urandom_range(TABLE_ENTRIES-1, 0)] + $urandom_range(1, 0));
        if (a > b) begin
            t = a;
            a = b;
            b = t;
        end
        if (b > 32'h7FFF_FFFF) b = 32'h7FFF_FFFF;
        if (a > b) a = b;
        return U_W'($urandom_range(b, a));
    endfunction

    // Table rewrite that keeps the entry between its neighbours, or noise
    task automatic random_load();
        int unsigned      k;
        logic [CDF_W-1:0] lo_v, hi_v, val;
        k    = $urandom_range(TABLE_ENTRIES-1, 0);
        lo_v = (k == 0) ? '0 : sb.cdf_mem[k-1];
        hi_v = (k == TABLE_ENTRIES-1) ? sb.cdf_mem[k] : sb.cdf_mem[k+1];
        if (lo_v > hi_v || $urandom_range(0, 99) < 15) val = $urandom;
        else val = $urandom_range(hi_v, lo_v);
        do_load(IDX_W'(k), val);
    endtask

    task automatic run_mix(input int n_items);
        repeat (n_items) begin
            if ($urandom_range(0, 99) < 20) random_load();
            else do_draw(pick_draw());
        end
    endtask

    initial begin : stimulus
        int               flat_k, narrow_k;
        logic [CDF_W-1:0] keep_v;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Rising table, grid step still at its reset value
        fill_cdf(1'b0);
        flat_k = TABLE_ENTRIES / 2;
        for (int k = 1; k < TABLE_ENTRIES; k++)
            if (flat_k == TABLE_ENTRIES / 2 && sb.cdf_mem[k] == sb.cdf_mem[k-1]) flat_k = k;
        narrow_k = 1000;
        while (narrow_k < TABLE_ENTRIES - 2 &&
               sb.cdf_mem[narrow_k-1] >= sb.cdf_mem[narrow_k+1])
            narrow_k++;

        // Directed: both clamps, exact entries, a flat run, a one-LSB interval
        do_draw('0);
        do_draw(U_W'(sb.cdf_mem[0]));
        do_draw(U_W'(sb.cdf_mem[0] + 1));
        do_draw('1);
        do_draw(U_W'(sb.cdf_mem[TABLE_ENTRIES-1]));
        do_draw(U_W'(sb.cdf_mem[flat_k]));
        do_draw(U_W'(sb.cdf_mem[TABLE_ENTRIES/2] - 1));
        do_load(IDX_W'(narrow_k), sb.cdf_mem[narrow_k-1] + 1);
        do_draw(U_W'(sb.cdf_mem[narrow_k]));
        // Top entry at exactly 1.0, then above every draw
        keep_v = sb.cdf_mem[TABLE_ENTRIES-1];
        do_load(IDX_W'(TABLE_ENTRIES-1), 32'h8000_0000);
        do_draw('1);
        do_load(IDX_W'(TABLE_ENTRIES-1), '1);
        do_draw('1);
        do_load(IDX_W'(TABLE_ENTRIES-1), keep_v);
        // First entry at zero
        keep_v = sb.cdf_mem[0];
        do_load('0, '0);
        do_draw('0);
        do_draw(U_W'(1));
        do_load('0, keep_v);

        // Random, with one full drain and one long output hold-off
        run_mix(100);
        wait_drained();
        run_mix(60);
        hold_go <= 1'b1;
        repeat (40) do_draw(pick_draw());
        run_mix(100);

        write_step('0);
        run_mix(150);

        // Largest step with no idling on either side
        write_step('1);
        quiet <= 1'b1;
        run_mix(250);
        wait_drained();
        quiet <= 1'b0;

        write_step(STEP_W'($urandom));
        run_mix(250);

        // Scrambled, non-monotone table
        write_step(STEP_W'(1));
        fill_cdf(1'b1);
        run_mix(250);

        write_step(STEP_W'($urandom));
        run_mix(250);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Checked %0d energies from %0d draws and %0d table writes",
                 sb.checked, sb.n_draws, sb.n_loads);
        $display("Outcomes: %0d low clamps, %0d high clamps, %0d interpolated",
                 sb.n_low, sb.n_high, sb.n_interp);
        if (sb.fails == 0 && sb.pending() == 0) begin
            $display("inverse_cdf_table_sampler verification clean");
        end else begin
            $display("inverse_cdf_table_sampler verification failed");
        end
        $finish;
    end
endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/icts_pkg.sv
rtl/core/icts_ctrl.sv
rtl/core/icts_dpath.sv
rtl/core/inverse_cdf_table_sampler.sv
tb/testbench.sv
